FILE: hdl/rmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmt_pkg
// Shared types and constants of the rate-monotonic task table.
// ----------------------------------------------------------------------------
package rmt_pkg;

    localparam int ID_W     = 16;
    localparam int PER_W    = 16;
    localparam int COMP_W   = 8;
    localparam int TERM_W   = 24;
    localparam int UTIL_W   = 28;
    localparam int REL_W    = 17;

    localparam logic [UTIL_W-1:0] UTIL_MAX    = 28'hFFF_FFFF;
    localparam logic [UTIL_W-1:0] LIMIT_RESET = 28'd45875;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_IDX  = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PER_W-1:0]  period;
        logic [COMP_W-1:0] comp;
        logic [TERM_W-1:0] term;
    } t_entry;

endpackage

FILE: hdl/rate_monotonic_task_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rate_monotonic_task_table
// Task table kept sorted by period, longest first, with utilization tracking.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. func selects
// insert, delete at a sorted position, or read at a sorted position. Exactly
// one result word follows, shown for one cycle with o_done high; the receiver
// cannot stall it, and the next command may be issued in that same cycle.
// The time from acceptance to o_done is set by the single table memory port
// and the serial divider:
//   insert: the divider runs, each entry moved is read and rewritten, then the new entry is written,
//   delete: reads the deleted term, then moves each entry behind it up one place,
//   read:   reads the entries from the head up to the read position (rank scan),
//   errors and no-op: go straight to the result.
// Utilization is kept as an exact running sum of the stored per-task terms
// and reported saturated to 28 bits. util_limit is written through
// i_cfg_we / i_cfg_wdata, by the user while idle (not enforced). Reset empties
// the table (not its memory), clears the sums, sets util_limit to about 0.7.
// ----------------------------------------------------------------------------
module rate_monotonic_task_table import rmt_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_func,
    input  logic [ID_W-1:0]   i_task_id,
    input  logic [PER_W-1:0]  i_period,
    input  logic [COMP_W-1:0] i_computation,
    input  logic [PER_W-1:0]  i_arrival,
    input  logic [3:0]        i_index,
    input  logic              i_cfg_we,
    input  logic [UTIL_W-1:0] i_cfg_wdata,
    output logic              o_done,
    output logic [1:0]        o_status,
    output logic [4:0]        o_task_count,
    output logic [UTIL_W-1:0] o_utilization,
    output logic              o_over_limit,
    output logic [ID_W-1:0]   o_entry_id,
    output logic [PER_W-1:0]  o_entry_period,
    output logic [COMP_W-1:0] o_entry_computation,
    output logic [4:0]        o_entry_priority,
    output logic [REL_W-1:0]  o_latest_release
);

    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int PW   = $clog2(TABLE_DEPTH);
    localparam int SW   = TERM_W + CW;
    localparam int CMPW = (CW > 4) ? CW : 4;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_REQ, S_USE, S_OUT} t_state;

    t_state r_state;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd;

    logic [1:0]        r_func;
    logic [ID_W-1:0]   r_id;
    logic [PER_W-1:0]  r_per;
    logic [COMP_W-1:0] r_comp;
    logic [PER_W-1:0]  r_arr;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_ptr;
    logic [CW-1:0]     r_rank;
    logic [PER_W-1:0]  r_prev;
    logic              r_first;
    logic [TERM_W-1:0] r_term;
    logic [1:0]        r_status;
    logic [ID_W-1:0]   r_eid;
    logic [PER_W-1:0]  r_eper;
    logic [COMP_W-1:0] r_ecomp;
    logic [CW-1:0]     r_epri;

    logic [CW-1:0]     r_count;
    logic [SW-1:0]     r_sum;
    logic [REL_W-1:0]  r_max;
    logic [UTIL_W-1:0] r_limit;

    logic              div_start;
    logic [TERM_W-1:0] div_q;
    logic              div_done;

    logic              mem_we;
    logic [PW-1:0]     mem_waddr;
    t_entry            mem_wdata;
    logic [CW-1:0]     rsel;
    t_entry            new_entry;
    logic              full;
    logic              idx_bad;
    logic [REL_W-1:0]  rel;
    logic [CW-1:0]     ptr_inc;
    logic [CW-1:0]     n_rank;
    logic [31:0]       sum_wide;
    logic [UTIL_W-1:0] sum_sat;

    rmt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_comp  (i_computation),
        .i_per   (i_period),
        .o_quot  (div_q),
        .o_done  (div_done)
    );

    always_comb begin
        full      = (r_count >= CW'(TABLE_DEPTH));
        idx_bad   = (CMPW'(i_index) >= CMPW'(r_count));
        div_start = (r_state == S_IDLE) && start && (i_func == FUNC_INSERT) && !full;
        new_entry = '{id: r_id, period: r_per, comp: r_comp, term: r_term};
        rel       = {1'b0, r_arr} + {1'b0, r_per};
        ptr_inc   = r_ptr + CW'(1);
        n_rank    = r_rank;
        if ((r_ptr != '0) && (r_rd.period != r_prev)) begin
            n_rank = r_rank + CW'(1);
        end
        sum_wide  = 32'(r_sum);
        sum_sat   = (sum_wide > 32'(UTIL_MAX)) ? UTIL_MAX : sum_wide[UTIL_W-1:0];

        case (r_func)
            FUNC_INSERT: rsel = r_ptr - CW'(1);
            FUNC_DELETE: rsel = r_first ? r_ptr : ptr_inc;
            default:     rsel = r_ptr;
        endcase

        mem_we    = 1'b0;
        mem_waddr = r_ptr[PW-1:0];
        mem_wdata = new_entry;
        if (r_func == FUNC_INSERT) begin
            if ((r_state == S_REQ) && (r_ptr == '0)) begin
                mem_we = 1'b1;
            end else if (r_state == S_USE) begin
                mem_we = 1'b1;
                // Entries with a shorter period move down one place.
                if (r_rd.period < r_per) begin
                    mem_wdata = r_rd;
                end
            end
        end else if ((r_func == FUNC_DELETE) && (r_state == S_USE) && !r_first) begin
            mem_we    = 1'b1;
            mem_wdata = r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[rsel[PW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_sum   <= '0;
            r_max   <= '0;
            r_limit <= LIMIT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_func   <= i_func;
                        r_id     <= i_task_id;
                        r_per    <= i_period;
                        r_comp   <= i_computation;
                        r_arr    <= i_arrival;
                        r_idx    <= CW'(CMPW'(i_index));
                        r_status <= STAT_OK;
                        r_eid    <= '0;
                        r_eper   <= '0;
                        r_ecomp  <= '0;
                        r_epri   <= '0;
                        r_first  <= 1'b1;
                        r_rank   <= CW'(1);
                        r_prev   <= '0;
                        case (i_func) inside
                            FUNC_INSERT: begin
                                if (full) begin
                                    r_status <= STAT_FULL;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_state <= S_DIV;
                                end
                            end
                            FUNC_DELETE, FUNC_READ: begin
                                if (idx_bad) begin
                                    r_status <= STAT_IDX;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_ptr   <= (i_func == FUNC_READ) ? '0
                                                                     : CW'(CMPW'(i_index));
                                    r_state <= S_REQ;
                                end
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_term  <= div_q;
                        r_ptr   <= r_count;
                        r_state <= S_REQ;
                    end
                end
                S_REQ: begin
                    if ((r_func == FUNC_INSERT) && (r_ptr == '0)) begin
                        r_count <= r_count + CW'(1);
                        r_sum   <= r_sum + SW'(r_term);
                        if (rel > r_max) r_max <= rel;
                        r_state <= S_OUT;
                    end else if ((r_func == FUNC_DELETE) && !r_first
                                 && (ptr_inc >= r_count)) begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_USE;
                    end
                end
                S_USE: begin
                    if (r_func == FUNC_INSERT) begin
                        if (r_rd.period < r_per) begin
                            r_ptr   <= r_ptr - CW'(1);
                            r_state <= S_REQ;
                        end else begin
                            r_count <= r_count + CW'(1);
                            r_sum   <= r_sum + SW'(r_term);
                            if (rel > r_max) r_max <= rel;
                            r_state <= S_OUT;
                        end
                    end else if (r_func == FUNC_DELETE) begin
                        if (r_first) begin
                            r_sum   <= r_sum - SW'(r_rd.term);
                            r_first <= 1'b0;
                        end else begin
                            r_ptr <= ptr_inc;
                        end
                        r_state <= S_REQ;
                    end else begin
                        // Dense rank: count period changes from the head.
                        r_rank <= n_rank;
                        r_prev <= r_rd.period;
                        if (r_ptr == r_idx) begin
                            r_eid   <= r_rd.id;
                            r_eper  <= r_rd.period;
                            r_ecomp <= r_rd.comp;
                            r_epri  <= n_rank;
                            r_state <= S_OUT;
                        end else begin
                            r_ptr   <= ptr_inc;
                            r_state <= S_REQ;
                        end
                    end
                end
                S_OUT: begin
                    o_done              <= 1'b1;
                    o_status            <= r_status;
                    o_task_count        <= 5'(r_count);
                    o_utilization       <= sum_sat;
                    o_over_limit        <= (sum_sat > r_limit);
                    o_entry_id          <= r_eid;
                    o_entry_period      <= r_eper;
                    o_entry_computation <= r_ecomp;
                    o_entry_priority    <= 5'(r_epri);
                    o_latest_release    <= r_max;
                    r_state             <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

FILE: hdl/rmt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmt_div
// Serial restoring divider: (computation << 16) / period, one bit a cycle.
// ----------------------------------------------------------------------------
module rmt_div import rmt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [COMP_W-1:0] i_comp,
    input  logic [PER_W-1:0]  i_per,
    output logic [TERM_W-1:0] o_quot,
    output logic              o_done
);

    localparam int CNT_W = $clog2(TERM_W + 1);

    logic [TERM_W-1:0] r_quot;
    logic [PER_W:0]    r_rem;
    logic [PER_W-1:0]  r_dsr;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_run;
    logic              r_done;

    logic [PER_W:0] rem_sh;
    logic           fits;

    always_comb begin
        rem_sh = {r_rem[PER_W-1:0], r_quot[TERM_W-1]};
        fits   = (rem_sh >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_start) begin
            r_quot <= {i_comp, {(TERM_W-COMP_W){1'b0}}};
            r_rem  <= '0;
            // A zero period divides as if it were one.
            r_dsr  <= (i_per == '0) ? PER_W'(1) : i_per;
            r_cnt  <= CNT_W'(TERM_W);
            r_run  <= 1'b1;
        end else if (r_run) begin
            r_rem  <= fits ? (rem_sh - {1'b0, r_dsr}) : rem_sh;
            r_quot <= {r_quot[TERM_W-2:0], fits};
            r_cnt  <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule
